>>> sv/lmcce_pkg.sv
package lmcce_pkg;

    localparam int GRID_DIM   = 20;
    localparam int CELL_TOTAL = GRID_DIM * GRID_DIM;
    localparam int IDX_W      = $clog2(GRID_DIM);
    localparam int LIVE_W     = $clog2(CELL_TOTAL + 1);
    localparam int COORD_W    = 5;
    localparam int DRAW_W     = 16;
    localparam int ACT_W      = 16;
    localparam int TOTAL_W    = 9;
    localparam int CFG_W      = 16;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GRID_DIM - 1);

    localparam logic [CFG_W-1:0] MOVE_THR_RESET  = 16'd10923;
    localparam logic [CFG_W-1:0] BIRTH_THR_RESET = 16'd43691;

    typedef enum logic [0:0] {
        CFG_MOVE_THR  = 1'b0,
        CFG_BIRTH_THR = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_EVENT = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        DIR_ROW_INC = 2'd0,
        DIR_ROW_DEC = 2'd1,
        DIR_COL_INC = 2'd2,
        DIR_COL_DEC = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_BIRTH = 2'd2,
        KIND_DEATH = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_SECOND,
        ST_EXEC,
        ST_WR_CENTER,
        ST_WR_NEIGH,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic rd_first;
        logic rd_second;
        logic exec;
        logic wr_center;
        logic wr_neigh;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wc_req;
        logic wn_req;
        logic out_free;
    } status_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
        return (v == IDX_LAST) ? '0 : IDX_W'(v + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v);
        return (v == '0) ? IDX_LAST : IDX_W'(v - 1'b1);
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [LIVE_W-1:0] v);
        return (int'(v) > 511) ? 9'd511 : TOTAL_W'(v);
    endfunction

endpackage

>>> sv/lmcce_ctrl.sv
module lmcce_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               in_ready,
    input  lmcce_pkg::status_t status,
    output lmcce_pkg::cmd_t    cmd
);
    import lmcce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST: begin
                cmd.rd_first = 1'b1;
                state_next   = ST_RD_SECOND;
            end
            ST_RD_SECOND: begin
                cmd.rd_second = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_WR_CENTER;
            end
            ST_WR_CENTER: begin
                cmd.wr_center = status.wc_req;
                state_next    = status.wn_req ? ST_WR_NEIGH : ST_DONE;
            end
            ST_WR_NEIGH: begin
                cmd.wr_neigh = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result until the output register is free.
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/lmcce_dpath.sv
module lmcce_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lmcce_pkg::cmd_t                  cmd,
    output lmcce_pkg::status_t               status,
    input  logic                             cfg_wr_en,
    input  logic [0:0]                       cfg_wr_index,
    input  logic [lmcce_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                             s_operation,
    input  logic [lmcce_pkg::COORD_W-1:0]    s_row,
    input  logic [lmcce_pkg::COORD_W-1:0]    s_column,
    input  logic [lmcce_pkg::DRAW_W-1:0]     s_event_draw,
    input  logic [1:0]                       s_direction,
    input  logic                             s_cell_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_event_kind,
    output logic                             m_changed,
    output logic [lmcce_pkg::TOTAL_W-1:0]    m_live_total,
    output logic                             m_extinct,
    output logic [lmcce_pkg::ACT_W-1:0]      m_action_total
);
    import lmcce_pkg::*;

    // Configuration
    logic [CFG_W-1:0] move_thr_reg;
    logic [CFG_W-1:0] birth_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_thr_reg  <= MOVE_THR_RESET;
            birth_thr_reg <= BIRTH_THR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_index))
                CFG_MOVE_THR:  move_thr_reg  <= cfg_wr_data;
                CFG_BIRTH_THR: birth_thr_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Captured input item
    op_t              op_reg;
    logic             in_range_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;
    logic [DRAW_W-1:0] draw_reg;
    dir_t             dir_reg;
    logic             val_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg       <= op_t'(s_operation);
            in_range_reg <= (int'(s_row) < GRID_DIM) && (int'(s_column) < GRID_DIM);
            row_reg      <= IDX_W'(s_row);
            col_reg      <= IDX_W'(s_column);
            draw_reg     <= s_event_draw;
            dir_reg      <= dir_t'(s_direction);
            val_reg      <= s_cell_value;
        end
    end

    logic [IDX_W-1:0] row_plus;
    logic [IDX_W-1:0] row_minus;
    logic [IDX_W-1:0] col_plus;
    logic [IDX_W-1:0] col_minus;

    assign row_plus  = wrap_inc(row_reg);
    assign row_minus = wrap_dec(row_reg);
    assign col_plus  = wrap_inc(col_reg);
    assign col_minus = wrap_dec(col_reg);

    // Row memory of the grid: one word per row, with a valid bit per row so
    // that a row never written reads as all dead.
    logic [GRID_DIM-1:0] mem [GRID_DIM];
    logic [GRID_DIM-1:0] row_valid_reg;
    logic [GRID_DIM-1:0] rdata_a_reg;
    logic [GRID_DIM-1:0] rdata_b_reg;

    logic [GRID_DIM-1:0] center_row_reg;
    logic [GRID_DIM-1:0] neigh_row_reg;
    logic [IDX_W-1:0]    neigh_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rd_first) begin
            rdata_a_reg <= row_valid_reg[row_reg] ? mem[row_reg] : '0;
            rdata_b_reg <= row_valid_reg[row_plus] ? mem[row_plus] : '0;
        end else if (cmd.rd_second) begin
            rdata_a_reg <= row_valid_reg[row_minus] ? mem[row_minus] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_center) begin
            mem[row_reg] <= center_row_reg;
        end else if (cmd.wr_neigh) begin
            mem[neigh_addr_reg] <= neigh_row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.wr_center) begin
            row_valid_reg[row_reg] <= 1'b1;
        end else if (cmd.wr_neigh) begin
            row_valid_reg[neigh_addr_reg] <= 1'b1;
        end
    end

    // Center row and the row above are held; the row below arrives last.
    logic [GRID_DIM-1:0] row_c_reg;
    logic [GRID_DIM-1:0] row_p_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rd_second) begin
            row_c_reg <= rdata_a_reg;
            row_p_reg <= rdata_b_reg;
        end
    end

    // Event decision
    logic [GRID_DIM-1:0] row_m;
    logic                alive;
    logic [3:0]          nbits;
    logic [2:0]          nb_cnt;
    kind_t               kind;
    dir_t                tk;
    logic                set_t;
    logic                clr_c;
    logic                chg;
    logic                inc;
    logic                dec;
    logic                wc_req;
    logic                wn_req;
    logic [GRID_DIM-1:0] center_new;
    logic [GRID_DIM-1:0] neigh_new;
    logic [IDX_W-1:0]    neigh_addr;

    assign row_m  = rdata_a_reg;
    assign alive  = row_c_reg[col_reg];
    assign nbits  = {row_c_reg[col_minus], row_c_reg[col_plus], row_m[col_reg],
                     row_p_reg[col_reg]};
    assign nb_cnt = 3'($countones(nbits));

    always_comb begin
        kind       = KIND_NONE;
        tk         = dir_reg;
        set_t      = 1'b0;
        clr_c      = 1'b0;
        chg        = 1'b0;
        inc        = 1'b0;
        dec        = 1'b0;
        center_new = row_c_reg;
        if (in_range_reg) begin
            if (op_reg == OP_WRITE) begin
                chg                 = alive != val_reg;
                inc                 = chg & val_reg;
                dec                 = chg & ~val_reg;
                center_new[col_reg] = val_reg;
            end else if (alive) begin
                if (draw_reg < move_thr_reg) begin
                    kind = KIND_MOVE;
                    tk   = dir_reg;
                    if (!nbits[dir_reg]) begin
                        set_t = 1'b1;
                        clr_c = 1'b1;
                    end
                end else if (draw_reg < birth_thr_reg) begin
                    kind = KIND_BIRTH;
                    if (nb_cnt inside {[3'd1:3'd3]}) begin
                        set_t = 1'b1;
                        if (!nbits[DIR_ROW_INC]) begin
                            tk = DIR_ROW_INC;
                        end else if (!nbits[DIR_ROW_DEC]) begin
                            tk = DIR_ROW_DEC;
                        end else if (!nbits[DIR_COL_INC]) begin
                            tk = DIR_COL_INC;
                        end else begin
                            tk = DIR_COL_DEC;
                        end
                    end
                end else begin
                    kind = KIND_DEATH;
                    clr_c = (nb_cnt == 3'd4);
                end
                chg = set_t | clr_c;
                inc = set_t;
                dec = clr_c;
                if (set_t && tk == DIR_COL_INC) begin
                    center_new[col_plus] = 1'b1;
                end
                if (set_t && tk == DIR_COL_DEC) begin
                    center_new[col_minus] = 1'b1;
                end
                if (clr_c) begin
                    center_new[col_reg] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        neigh_new           = (tk == DIR_ROW_INC) ? row_p_reg : row_m;
        neigh_new[col_reg]  = 1'b1;
        neigh_addr          = (tk == DIR_ROW_INC) ? row_plus : row_minus;
    end

    // The center row is rewritten for a flipped write, a cleared cell or a
    // birth or move along the row; the other row only for a row-wise target.
    assign wc_req = (op_reg == OP_WRITE && chg) || clr_c ||
                    (set_t && (tk == DIR_COL_INC || tk == DIR_COL_DEC));
    assign wn_req = set_t && (tk == DIR_ROW_INC || tk == DIR_ROW_DEC);

    // Results and counters
    kind_t             kind_reg;
    logic              changed_reg;
    logic              wc_req_reg;
    logic              wn_req_reg;
    logic [LIVE_W-1:0] live_reg;
    logic [ACT_W-1:0]  action_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            kind_reg       <= kind;
            changed_reg    <= chg;
            center_row_reg <= center_new;
            neigh_row_reg  <= neigh_new;
            neigh_addr_reg <= neigh_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_req_reg <= 1'b0;
            wn_req_reg <= 1'b0;
            live_reg   <= '0;
            action_reg <= '0;
        end else if (cmd.exec) begin
            wc_req_reg <= wc_req;
            wn_req_reg <= wn_req;
            live_reg   <= LIVE_W'(live_reg + LIVE_W'(inc) - LIVE_W'(dec));
            if (op_reg == OP_EVENT && chg) begin
                action_reg <= ACT_W'(action_reg + 1'b1);
            end
        end
    end

    // Output register
    logic               m_valid_reg;
    logic [1:0]         m_kind_reg;
    logic               m_changed_reg;
    logic [TOTAL_W-1:0] m_total_reg;
    logic               m_extinct_reg;
    logic [ACT_W-1:0]   m_action_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_kind_reg    <= kind_reg;
            m_changed_reg <= changed_reg;
            m_total_reg   <= sat_total(live_reg);
            m_extinct_reg <= (live_reg == '0);
            m_action_reg  <= action_reg;
        end
    end

    assign status.wc_req   = wc_req_reg;
    assign status.wn_req   = wn_req_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = m_kind_reg;
    assign m_changed      = m_changed_reg;
    assign m_live_total   = m_total_reg;
    assign m_extinct      = m_extinct_reg;
    assign m_action_total = m_action_reg;

endmodule

>>> sv/lattice_monte_carlo_cell_event_unit.sv
// Lattice cell event engine on a toroidal grid of alive bits.
//
// Input channel (s_valid / s_ready): one item per transfer, either a random
// event at a cell (move, birth or death, chosen by s_event_draw against the
// two thresholds) or a write of one cell's alive bit. Coordinates outside the
// grid leave the state alone and return the current totals.
// Result channel (m_valid / m_ready): exactly one result per input item, in
// order, carrying the selected action, a changed flag and the totals.
// Configuration: cfg_wr_en with cfg_wr_index 0 (move threshold) or 1 (birth
// threshold); write only while the block is idle.
// Sequence: the grid is a row memory with two registered read ports and one
// write port. An item reads three rows (RD_FIRST, RD_SECOND), decides
// (EXEC), writes back (WR_CENTER, then WR_NEIGH when another row is rewritten)
// and loads the output register (DONE); a new item is taken only after the
// last one has loaded its result and the block is idle again.
// Reset clears all cells to dead at once through per-row valid bits, clears
// both counters and restores the default thresholds.
// A stalled receiver holds the result; the next item is still taken and runs
// until its own result is ready, then waits for the output register.
module lattice_monte_carlo_cell_event_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_wr_index,
    input  logic [lmcce_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [lmcce_pkg::COORD_W-1:0] s_row,
    input  logic [lmcce_pkg::COORD_W-1:0] s_column,
    input  logic [lmcce_pkg::DRAW_W-1:0]  s_event_draw,
    input  logic [1:0]                    s_direction,
    input  logic                          s_cell_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_event_kind,
    output logic                          m_changed,
    output logic [lmcce_pkg::TOTAL_W-1:0] m_live_total,
    output logic                          m_extinct,
    output logic [lmcce_pkg::ACT_W-1:0]   m_action_total
);
    import lmcce_pkg::*;

    cmd_t    cmd;
    status_t status;

    lmcce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lmcce_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_operation    (s_operation),
        .s_row          (s_row),
        .s_column       (s_column),
        .s_event_draw   (s_event_draw),
        .s_direction    (s_direction),
        .s_cell_value   (s_cell_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_changed      (m_changed),
        .m_live_total   (m_live_total),
        .m_extinct      (m_extinct),
        .m_action_total (m_action_total)
    );

endmodule
